[rtl/core/mcmp_pkg.sv]
`timescale 1ns / 1ps
// Package for the MIDI channel message parser: message kind codes, status
// nibble codes, the packed result type and the status-to-kind decode.
// Depends on nothing; used by mcmp_core and the top level.

package mcmp_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned DATA_W = 7;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned CHAN_W = 4;
	localparam int unsigned OUT_TDATA_W = 32;

	// Message kind codes as reported on the output.
	localparam logic [KIND_W-1:0] KIND_NOTE_OFF   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_NOTE_ON    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CTRL_CHG   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_PROG_CHG   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_PITCH_BEND = 3'd4;

	// High nibbles of the status bytes that select a kind.
	localparam logic [3:0] NIB_NOTE_OFF   = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON    = 4'h9;
	localparam logic [3:0] NIB_CTRL_CHG   = 4'hB;
	localparam logic [3:0] NIB_PROG_CHG   = 4'hC;
	localparam logic [3:0] NIB_PITCH_BEND = 4'hE;

	// Data slot positions.
	localparam logic [1:0] SLOT_NONE   = 2'd0;
	localparam logic [1:0] SLOT_FIRST  = 2'd1;
	localparam logic [1:0] SLOT_SECOND = 2'd2;

	// One finished message, last field in the lowest bits.
	typedef struct packed {
		logic [DATA_W-1:0] second_data;
		logic [DATA_W-1:0] first_data;
		logic [BYTE_W-1:0] status_value;
		logic [CHAN_W-1:0] msg_channel;
		logic [KIND_W-1:0] msg_kind;
	} msg_t;

	// Result of decoding a status byte's high nibble.
	typedef struct packed {
		logic              known;
		logic [KIND_W-1:0] kind;
	} kind_dec_t;

	function automatic kind_dec_t decode_kind(input logic [3:0] nib);
		kind_dec_t d;
		d.known = 1'b1;
		d.kind  = KIND_NOTE_OFF;
		unique case (nib)
			NIB_NOTE_OFF:   d.kind = KIND_NOTE_OFF;
			NIB_NOTE_ON:    d.kind = KIND_NOTE_ON;
			NIB_CTRL_CHG:   d.kind = KIND_CTRL_CHG;
			NIB_PROG_CHG:   d.kind = KIND_PROG_CHG;
			NIB_PITCH_BEND: d.kind = KIND_PITCH_BEND;
			default:        d.known = 1'b0;
		endcase
		return d;
	endfunction

endpackage

[rtl/core/mcmp_core.sv]
`timescale 1ns / 1ps
// Parser state and its update for one received byte.
// Depends on mcmp_pkg for codes, the message type and the kind decode.

module mcmp_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [mcmp_pkg::BYTE_W-1:0]   rx_byte,
	output logic                          emit,
	output mcmp_pkg::msg_t                msg
);
	import mcmp_pkg::*;

	logic              kind_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [1:0]        count_q;
	logic [BYTE_W-1:0] status_q;
	logic [DATA_W-1:0] data_one_q;
	logic [DATA_W-1:0] data_two_q;

	logic              is_status;
	kind_dec_t         dec;
	logic [1:0]        count_inc;
	logic [1:0]        last_slot;
	logic [DATA_W-1:0] data_one_nxt;
	logic [DATA_W-1:0] data_two_nxt;

	assign is_status = rx_byte[BYTE_W-1];
	assign dec       = decode_kind(rx_byte[BYTE_W-1 -: 4]);
	assign count_inc = (count_q == SLOT_SECOND) ? SLOT_NONE : count_q + 2'd1;
	assign last_slot = (kind_q == KIND_PROG_CHG) ? SLOT_FIRST : SLOT_SECOND;

	assign data_one_nxt = (count_inc == SLOT_FIRST)  ? rx_byte[DATA_W-1:0] : data_one_q;
	assign data_two_nxt = (count_inc == SLOT_SECOND) ? rx_byte[DATA_W-1:0] : data_two_q;

	assign emit = !is_status && kind_valid_q && (count_inc == last_slot);

	always_comb begin
		msg.msg_kind     = kind_q;
		msg.msg_channel  = status_q[CHAN_W-1:0];
		msg.status_value = status_q;
		msg.first_data   = data_one_nxt;
		msg.second_data  = data_two_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_valid_q <= 1'b0;
			kind_q       <= KIND_NOTE_OFF;
			count_q      <= SLOT_NONE;
			status_q     <= '0;
			data_one_q   <= '0;
			data_two_q   <= '0;
		end else if (step) begin
			if (is_status) begin
				count_q  <= SLOT_NONE;
				status_q <= rx_byte;
				if (dec.known) begin
					kind_valid_q <= 1'b1;
					kind_q       <= dec.kind;
				end
			end else begin
				count_q    <= emit ? SLOT_NONE : count_inc;
				data_one_q <= data_one_nxt;
				data_two_q <= data_two_nxt;
			end
		end
	end

endmodule

[rtl/core/midi_channel_message_parser_top.sv]
`timescale 1ns / 1ps
// MIDI channel voice message parser with running status.
// Path: a transferred byte sits in the input register (byte stage), and its
// message is registered in the result register before it shows on m_tvalid.
// Throughput: one byte per cycle; the byte stage stalls only when a finished
// message is waiting in the result register and the sink holds m_tready low.
// Reset: arst_n clears valid flags and parser state; no kind known, nothing sent.

module midi_channel_message_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	// Received byte stream. s_tdata: [7:0] rx_byte.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// Message stream. m_tdata: [2:0] msg_kind, [6:3] msg_channel,
	// [14:7] status_value, [21:15] first_data, [28:22] second_data, [31:29] zero.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata
);
	import mcmp_pkg::*;

	// Byte stage. It holds one received byte until the parser can take it.
	logic              byte_valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// Result register, which parts the sink's backpressure from the parser.
	logic              out_valid_q;
	msg_t              out_msg_q;

	logic              core_emit;
	msg_t              core_msg;
	logic              out_free;
	logic              advance;

	// A byte that finishes no message never needs the result register, so it
	// moves on even while the sink is stalled.
	assign out_free = !out_valid_q || m_tready;
	assign advance  = byte_valid_s1 && (!core_emit || out_free);
	assign s_tready = !byte_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			byte_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	mcmp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.emit    (core_emit),
		.msg     (core_msg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && core_emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && core_emit) begin
			out_msg_q <= core_msg;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - $bits(msg_t)){1'b0}}, out_msg_q};

endmodule

[rtl/core/mcmp_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the MIDI channel message parser, bound to the top level.
// Depends only on the top level's port names.

module mcmp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// A stalled message stays in place until its transfer.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("message changed while stalled");

	// Only known kinds are ever reported.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] <= 3'd4))
		else $error("unknown message kind");

	// The stored status is always a status byte once a message goes out.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[14])
		else $error("status value without status flag");

	// Channel is the low nibble of the reported status byte.
	a_chan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:3] == m_tdata[10:7]))
		else $error("channel does not match status byte");

	// Padding bits stay zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[31:29] == 3'd0))
		else $error("nonzero padding in message");

endmodule

bind midi_channel_message_parser_top mcmp_checker u_mcmp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
